>>> rtl/pidc_pkg.sv
`default_nettype none

package pidc_pkg;

  // Field widths
  localparam int unsigned IdW      = 24;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned RadixW   = 9;
  localparam int unsigned NumChan  = 3;

  // Derived configuration widths (radix is at most 256 whenever the step is nonzero)
  localparam int unsigned SqW      = 2 * ChanW + 1;   // radix squared, up to 2^16
  localparam int unsigned CubeW    = IdW + 1;         // radix cubed, up to 2^24
  localparam int unsigned InvR2W   = IdW - 1;         // floor(2^IdW / r2), r2 >= 4
  localparam int unsigned InvRW    = SqW;             // floor(2^SqW / r), r >= 2
  localparam int unsigned InvSW    = ChanW + 1;       // floor(2^ChanW / step), step >= 1

  // Datapath pipeline depth
  localparam int unsigned NumStages = 7;

  // Shared bit-serial divider in the configuration unit
  localparam int unsigned DivW     = CubeW;
  localparam int unsigned DvsW     = SqW;
  localparam int unsigned DivCntW  = $clog2(DivW);

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = RadixW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIGIT_RADIX = 1'b0,
    CFG_FULL_SCALE  = 1'b1
  } pidc_cfg_idx_e;

  typedef enum logic {
    OP_ID_TO_COLOR = 1'b0,
    OP_COLOR_TO_ID = 1'b1
  } pidc_op_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SQUARE,
    SEQ_CUBE,
    SEQ_DIVIDE
  } pidc_seq_e;

  typedef enum logic [1:0] {
    JOB_STEP,
    JOB_INV_R2,
    JOB_INV_R,
    JOB_INV_S
  } pidc_job_e;

  typedef struct packed {
    logic [RadixW-1:0] radix;
    logic [ChanW-1:0]  step;
    logic              zero_step;
    logic [SqW-1:0]    r2;
    logic [CubeW-1:0]  r3;
    logic [InvR2W-1:0] inv_r2;
    logic [InvRW-1:0]  inv_r;
    logic [InvSW-1:0]  inv_s;
  } pidc_cfg_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } pidc_pipe_t;

endpackage

`default_nettype wire

>>> rtl/pidc_cfg.sv
`default_nettype none

module pidc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pidc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pidc_pkg::CfgDataW-1:0] cfg_data_i,
  output pidc_pkg::pidc_cfg_t        cfg_o,
  output logic                       busy_o
);
  import pidc_pkg::*;

  localparam logic [DivW-1:0] DivOneR2 = DivW'(1) << IdW;
  localparam logic [DivW-1:0] DivOneR  = DivW'(1) << SqW;
  localparam logic [DivW-1:0] DivOneS  = DivW'(1) << ChanW;

  logic                cfg_wr;
  logic [RadixW-1:0]   radix_q;
  logic [ChanW-1:0]    scale_q;

  pidc_seq_e           seq_q, seq_d;
  pidc_job_e           job_q, job_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [DvsW:0]       rem_q, rem_d;
  logic [DivW-1:0]     quo_q, quo_d;
  logic [DvsW-1:0]     dvs_q, dvs_d;

  logic [ChanW-1:0]    step_q, step_d;
  logic [SqW-1:0]      r2_q, r2_d;
  logic [CubeW-1:0]    r3_q, r3_d;
  logic [InvR2W-1:0]   inv_r2_q, inv_r2_d;
  logic [InvRW-1:0]    inv_r_q, inv_r_d;
  logic [InvSW-1:0]    inv_s_q, inv_s_d;

  logic [2*RadixW-1:0]   sq_full;
  logic [SqW+RadixW-1:0] cube_full;
  logic [DvsW:0]         rem_sh;
  logic [DvsW:0]         rem_nx;
  logic [DivW-1:0]       quo_nx;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixW'(256);
      scale_q <= ChanW'(255);
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_DIGIT_RADIX: radix_q <= cfg_data_i;
        CFG_FULL_SCALE:  scale_q <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  assign sq_full   = radix_q * radix_q;
  assign cube_full = r2_q * radix_q;
  assign rem_sh    = {rem_q[DvsW-1:0], quo_q[DivW-1]};

  always_comb begin
    if (rem_sh >= {1'b0, dvs_q}) begin
      rem_nx = rem_sh - {1'b0, dvs_q};
      quo_nx = {quo_q[DivW-2:0], 1'b1};
    end else begin
      rem_nx = rem_sh;
      quo_nx = {quo_q[DivW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_SQUARE;
      job_q <= JOB_STEP;
      cnt_q <= '0;
    end else begin
      seq_q <= seq_d;
      job_q <= job_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    dvs_q    <= dvs_d;
    step_q   <= step_d;
    r2_q     <= r2_d;
    r3_q     <= r3_d;
    inv_r2_q <= inv_r2_d;
    inv_r_q  <= inv_r_d;
    inv_s_q  <= inv_s_d;
  end

  always_comb begin
    seq_d    = seq_q;
    job_d    = job_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    step_d   = step_q;
    r2_d     = r2_q;
    r3_d     = r3_q;
    inv_r2_d = inv_r2_q;
    inv_r_d  = inv_r_q;
    inv_s_d  = inv_s_q;

    case (seq_q)
      SEQ_IDLE: ;
      SEQ_SQUARE: begin
        r2_d  = sq_full[SqW-1:0];
        seq_d = SEQ_CUBE;
      end
      SEQ_CUBE: begin
        r3_d  = cube_full[CubeW-1:0];
        rem_d = '0;
        quo_d = DivW'(scale_q);
        dvs_d = DvsW'(radix_q - RadixW'(1));
        cnt_d = DivCntW'(DivW - 1);
        job_d = JOB_STEP;
        seq_d = SEQ_DIVIDE;
      end
      SEQ_DIVIDE: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q - DivCntW'(1);
        if (cnt_q == '0) begin
          // job done: store quotient, set up the next one, or go idle after the last
          rem_d = '0;
          cnt_d = DivCntW'(DivW - 1);
          case (job_q)
            JOB_STEP: begin
              step_d = quo_nx[ChanW-1:0];
              quo_d  = DivOneR2;
              dvs_d  = r2_q;
              job_d  = JOB_INV_R2;
            end
            JOB_INV_R2: begin
              inv_r2_d = quo_nx[InvR2W-1:0];
              quo_d    = DivOneR;
              dvs_d    = DvsW'(radix_q);
              job_d    = JOB_INV_R;
            end
            JOB_INV_R: begin
              inv_r_d = quo_nx[InvRW-1:0];
              quo_d   = DivOneS;
              dvs_d   = DvsW'(step_q);
              job_d   = JOB_INV_S;
            end
            JOB_INV_S: begin
              inv_s_d = quo_nx[InvSW-1:0];
              seq_d   = SEQ_IDLE;
            end
            default: seq_d = SEQ_IDLE;
          endcase
        end
      end
      default: seq_d = SEQ_SQUARE;
    endcase

    // any write restarts the precompute
    if (cfg_wr) begin
      seq_d = SEQ_SQUARE;
    end
  end

  assign busy_o = (seq_q != SEQ_IDLE);

  always_comb begin
    cfg_o.radix     = radix_q;
    cfg_o.step      = step_q;
    cfg_o.zero_step = (radix_q[RadixW-1:1] == '0) || (step_q == '0);
    cfg_o.r2        = r2_q;
    cfg_o.r3        = r3_q;
    cfg_o.inv_r2    = inv_r2_q;
    cfg_o.inv_r     = inv_r_q;
    cfg_o.inv_s     = inv_s_q;
  end

endmodule

`default_nettype wire

>>> rtl/pidc_enc.sv
`default_nettype none

module pidc_enc (
  input  logic                       clk_i,
  input  pidc_pkg::pidc_pipe_t       pipe_i,
  input  pidc_pkg::pidc_cfg_t        cfg_i,
  input  logic [pidc_pkg::IdW-1:0]   object_id_i,
  output logic [pidc_pkg::ChanW-1:0] red_level_o,
  output logic [pidc_pkg::ChanW-1:0] green_level_o,
  output logic [pidc_pkg::ChanW-1:0] blue_level_o,
  output logic                       oor_o
);
  import pidc_pkg::*;

  // s1: reciprocal estimate of id / r2
  logic [IdW+InvR2W-1:0] prod1;
  logic [RadixW-1:0]     q1_q;
  logic [IdW-1:0]        id1_q;
  logic                  oor1_q;

  // s2: back-multiply
  logic [SqW+RadixW-1:0] m2_q;
  logic [RadixW-1:0]     q2_q;
  logic [IdW-1:0]        id2_q;
  logic                  oor2_q;

  // s3: correct red digit
  logic [SqW+RadixW-1:0] diff3;
  logic [SqW:0]          dlow3;
  logic [ChanW-1:0]      dr3_d, dr3_q;
  logic [SqW-1:0]        rem3_d, rem3_q;
  logic                  oor3_q;

  // s4: reciprocal estimate of rem / r
  logic [SqW+InvRW-1:0]  prod4;
  logic [RadixW-1:0]     g4_q;
  logic [SqW-1:0]        rem4_q;
  logic [ChanW-1:0]      dr4_q;
  logic                  oor4_q;

  // s5: back-multiply
  logic [2*RadixW-1:0]   mg5_q;
  logic [RadixW-1:0]     g5_q;
  logic [SqW-1:0]        rem5_q;
  logic [ChanW-1:0]      dr5_q;
  logic                  oor5_q;

  // s6: correct green digit, blue is the remainder
  logic [SqW:0]          diff6;
  logic [RadixW:0]       dlow6;
  logic [ChanW-1:0]      dg6_d, db6_d;
  logic [ChanW-1:0]      dr6_q, dg6_q, db6_q;
  logic                  oor6_q;

  // s7: scale digits to levels
  logic [2*ChanW-1:0]    lr7, lg7, lb7;
  logic [ChanW-1:0]      lr7_q, lg7_q, lb7_q;
  logic                  oor7_q;

  assign prod1 = object_id_i * cfg_i.inv_r2;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[0]) begin
      q1_q   <= prod1[IdW +: RadixW];
      id1_q  <= object_id_i;
      oor1_q <= ({1'b0, object_id_i} >= cfg_i.r3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[1]) begin
      m2_q   <= q1_q * cfg_i.r2;
      q2_q   <= q1_q;
      id2_q  <= id1_q;
      oor2_q <= oor1_q;
    end
  end

  always_comb begin
    diff3 = (SqW+RadixW)'(id2_q) - m2_q;
    dlow3 = diff3[SqW:0];
    if (dlow3 >= {1'b0, cfg_i.r2}) begin
      dr3_d  = q2_q[ChanW-1:0] + ChanW'(1);
      rem3_d = SqW'(dlow3 - {1'b0, cfg_i.r2});
    end else begin
      dr3_d  = q2_q[ChanW-1:0];
      rem3_d = dlow3[SqW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[2]) begin
      dr3_q  <= dr3_d;
      rem3_q <= rem3_d;
      oor3_q <= oor2_q;
    end
  end

  assign prod4 = rem3_q * cfg_i.inv_r;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[3]) begin
      g4_q   <= prod4[SqW +: RadixW];
      rem4_q <= rem3_q;
      dr4_q  <= dr3_q;
      oor4_q <= oor3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[4]) begin
      mg5_q  <= g4_q * cfg_i.radix;
      g5_q   <= g4_q;
      rem5_q <= rem4_q;
      dr5_q  <= dr4_q;
      oor5_q <= oor4_q;
    end
  end

  always_comb begin
    diff6 = {1'b0, rem5_q} - (SqW+1)'(mg5_q);
    dlow6 = diff6[RadixW:0];
    if (dlow6 >= {1'b0, cfg_i.radix}) begin
      dg6_d = g5_q[ChanW-1:0] + ChanW'(1);
      db6_d = ChanW'(dlow6 - {1'b0, cfg_i.radix});
    end else begin
      dg6_d = g5_q[ChanW-1:0];
      db6_d = dlow6[ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[5]) begin
      dr6_q  <= dr5_q;
      dg6_q  <= dg6_d;
      db6_q  <= db6_d;
      oor6_q <= oor5_q;
    end
  end

  assign lr7 = dr6_q * cfg_i.step;
  assign lg7 = dg6_q * cfg_i.step;
  assign lb7 = db6_q * cfg_i.step;

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[6]) begin
      lr7_q  <= lr7[ChanW-1:0];
      lg7_q  <= lg7[ChanW-1:0];
      lb7_q  <= lb7[ChanW-1:0];
      oor7_q <= oor6_q;
    end
  end

  assign red_level_o   = lr7_q;
  assign green_level_o = lg7_q;
  assign blue_level_o  = lb7_q;
  assign oor_o         = oor7_q;

endmodule

`default_nettype wire

>>> rtl/pidc_dec.sv
`default_nettype none

module pidc_dec (
  input  logic                       clk_i,
  input  pidc_pkg::pidc_pipe_t       pipe_i,
  input  pidc_pkg::pidc_cfg_t        cfg_i,
  input  logic [pidc_pkg::ChanW-1:0] red_in_i,
  input  logic [pidc_pkg::ChanW-1:0] green_in_i,
  input  logic [pidc_pkg::ChanW-1:0] blue_in_i,
  output logic [pidc_pkg::IdW-1:0]   decoded_id_o
);
  import pidc_pkg::*;

  // lane 0 red, 1 green, 2 blue
  logic [NumChan-1:0][ChanW-1:0]       vin;
  logic [NumChan-1:0][ChanW+InvSW-1:0] pq1;
  logic [NumChan-1:0][ChanW-1:0]       lo1_q, v1_q;
  logic [NumChan-1:0][2*ChanW-1:0]     ml2_q;
  logic [NumChan-1:0][ChanW-1:0]       lo2_q, v2_q;
  logic [NumChan-1:0][ChanW:0]         diff3;
  logic [NumChan-1:0][ChanW-1:0]       lo3_d, rem3_d, lo3_q, rem3_q;
  logic [NumChan-1:0][RadixW-1:0]      dup4;
  logic [NumChan-1:0][ChanW-1:0]       d4_d, d4_q;
  logic [RadixW-1:0]                   rmax;

  logic [ChanW+SqW-1:0]    pr5_q;
  logic [ChanW+RadixW-1:0] pg5_q;
  logic [ChanW-1:0]        db5_q;
  logic [ChanW+SqW-1:0]    part6_q;
  logic [ChanW-1:0]        db6_q;
  logic [ChanW+SqW-1:0]    sum7;
  logic [IdW-1:0]          id7_q;

  assign vin[0] = red_in_i;
  assign vin[1] = green_in_i;
  assign vin[2] = blue_in_i;
  assign rmax   = cfg_i.radix - RadixW'(1);

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      pq1[c] = vin[c] * cfg_i.inv_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[0]) begin
      for (int c = 0; c < NumChan; c++) begin
        lo1_q[c] <= pq1[c][ChanW +: ChanW];
        v1_q[c]  <= vin[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[1]) begin
      for (int c = 0; c < NumChan; c++) begin
        ml2_q[c] <= lo1_q[c] * cfg_i.step;
        lo2_q[c] <= lo1_q[c];
        v2_q[c]  <= v1_q[c];
      end
    end
  end

  // estimate can be one low: fix quotient and remainder
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      diff3[c] = {1'b0, v2_q[c]} - ml2_q[c][ChanW:0];
      if (diff3[c] >= {1'b0, cfg_i.step}) begin
        lo3_d[c]  = lo2_q[c] + ChanW'(1);
        rem3_d[c] = ChanW'(diff3[c] - {1'b0, cfg_i.step});
      end else begin
        lo3_d[c]  = lo2_q[c];
        rem3_d[c] = diff3[c][ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[2]) begin
      lo3_q  <= lo3_d;
      rem3_q <= rem3_d;
    end
  end

  // round half up, then clamp to the top digit
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      if ((rem3_q[c] != '0) && ((cfg_i.step - rem3_q[c]) <= rem3_q[c])) begin
        dup4[c] = {1'b0, lo3_q[c]} + RadixW'(1);
      end else begin
        dup4[c] = {1'b0, lo3_q[c]};
      end
      if (dup4[c] > rmax) begin
        d4_d[c] = rmax[ChanW-1:0];
      end else begin
        d4_d[c] = dup4[c][ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[3]) begin
      d4_q <= d4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[4]) begin
      pr5_q <= d4_q[0] * cfg_i.r2;
      pg5_q <= d4_q[1] * cfg_i.radix;
      db5_q <= d4_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[5]) begin
      part6_q <= pr5_q + (ChanW+SqW)'(pg5_q);
      db6_q   <= db5_q;
    end
  end

  assign sum7 = part6_q + (ChanW+SqW)'(db6_q);

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[6]) begin
      id7_q <= sum7[IdW-1:0];
    end
  end

  assign decoded_id_o = id7_q;

endmodule

`default_nettype wire

>>> rtl/picking_id_color_codec_unit.sv
`default_nettype none

// Picking-ID color codec. op 0 splits object_id into three base-radix digits
// (red most significant) and returns digit*step per channel, where
// step = channel_full_scale / (digit_radix - 1); ok drops for an id of radix
// cubed or more. op 1 rounds each channel to the nearest step multiple (ties
// up, clamped at radix-1) and rebuilds the id. A zero step gives ok=0 with all
// fields zero; fields unused by the op read zero.
// Throughput is one transaction per cycle while in_stall_o stays low, through
// a 7-stage pipeline: the divisions by radix squared, radix and step run as
// multiplications by reciprocals with a one-step correction. Those reciprocals
// and the step are computed by a shared bit-serial divider, the radix powers
// by multiplication, whenever configuration changes: after reset and after
// every register write the input stalls while the square, the cube and four
// divisions are computed. Configuration writes are always taken (cfg_ready_o is
// tied high); a write restarts that computation. The output register holds a
// result under out_stall_i while empty stages upstream keep filling.

module picking_id_color_codec_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pidc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pidc_pkg::CfgDataW-1:0] cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [pidc_pkg::IdW-1:0]      object_id_i,
  input  logic [pidc_pkg::ChanW-1:0]    red_in_i,
  input  logic [pidc_pkg::ChanW-1:0]    green_in_i,
  input  logic [pidc_pkg::ChanW-1:0]    blue_in_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [pidc_pkg::ChanW-1:0]    red_level_o,
  output logic [pidc_pkg::ChanW-1:0]    green_level_o,
  output logic [pidc_pkg::ChanW-1:0]    blue_level_o,
  output logic [pidc_pkg::IdW-1:0]      decoded_id_o
);
  import pidc_pkg::*;

  pidc_cfg_t             cfg;
  logic                  cfg_busy;
  pidc_pipe_t            pipe;

  logic [NumStages-1:0]  valid_q, valid_d;
  logic [NumStages-1:0]  free;
  logic [NumStages-1:0]  op_q;
  logic                  accept;
  logic                  op_last;

  logic [ChanW-1:0]      lvl_r, lvl_g, lvl_b;
  logic                  oor;
  logic [IdW-1:0]        dec_id;

  // Config registers plus derived constants
  pidc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .busy_o      (cfg_busy)
  );

  // A stage can load when it is empty or its content moves on this cycle.
  always_comb begin
    free[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      free[k] = !valid_q[k] || free[k+1];
    end
  end

  assign in_stall_o = cfg_busy || !free[0];
  assign accept     = in_valid_i && !in_stall_o;
  assign pipe.load  = free;

  always_comb begin
    valid_d[0] = free[0] ? accept : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = free[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // op travels alongside the data
  always_ff @(posedge clk_i) begin
    if (free[0]) begin
      op_q[0] <= op_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (free[k]) begin
        op_q[k] <= op_q[k-1];
      end
    end
  end

  // id -> color lane
  pidc_enc u_enc (
    .clk_i         (clk_i),
    .pipe_i        (pipe),
    .cfg_i         (cfg),
    .object_id_i   (object_id_i),
    .red_level_o   (lvl_r),
    .green_level_o (lvl_g),
    .blue_level_o  (lvl_b),
    .oor_o         (oor)
  );

  // color -> id lane
  pidc_dec u_dec (
    .clk_i        (clk_i),
    .pipe_i       (pipe),
    .cfg_i        (cfg),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .decoded_id_o (dec_id)
  );

  // Output selection from the last stage registers. The user must keep config
  // static while a result is pending (not enforced here) so these hold under stall.
  assign op_last       = op_q[NumStages-1];
  assign out_valid_o   = valid_q[NumStages-1];
  assign ok_o          = !cfg.zero_step && ((op_last == OP_COLOR_TO_ID) || !oor);
  assign red_level_o   = (ok_o && (op_last == OP_ID_TO_COLOR)) ? lvl_r : '0;
  assign green_level_o = (ok_o && (op_last == OP_ID_TO_COLOR)) ? lvl_g : '0;
  assign blue_level_o  = (ok_o && (op_last == OP_ID_TO_COLOR)) ? lvl_b : '0;
  assign decoded_id_o  = (ok_o && (op_last == OP_COLOR_TO_ID)) ? dec_id : '0;

  // An accepted transaction lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q[0])
    else $error("accepted transaction missing from first stage");

  // A valid item in the first stage moves into a free second stage.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && free[1] |=> valid_q[1])
    else $error("item lost between first and second stage");

  // A new result only comes from the stage before the output.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(valid_q[NumStages-2]))
    else $error("result appeared without a preceding item");

  // A register write blocks input until the derived values are rebuilt.
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> cfg_busy && in_stall_o)
    else $error("config write did not restart precompute");

endmodule

`default_nettype wire

>>> tb/sv/pidc_codec_checker.sv
`timescale 1ns / 1ps

// Watches the codec ports, predicts every accepted transaction and compares results in order.
module pidc_codec_checker
  import pidc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                op_i,
  input  logic [IdW-1:0]      object_id_i,
  input  logic [ChanW-1:0]    red_in_i,
  input  logic [ChanW-1:0]    green_in_i,
  input  logic [ChanW-1:0]    blue_in_i,

  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                ok_i,
  input  logic [ChanW-1:0]    red_level_i,
  input  logic [ChanW-1:0]    green_level_i,
  input  logic [ChanW-1:0]    blue_level_i,
  input  logic [IdW-1:0]      decoded_id_i,

  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic             ok;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [IdW-1:0]   id;
  } codec_result_t;

  logic [RadixW-1:0] radix_q;
  logic [ChanW-1:0]  scale_q;
  codec_result_t     awaited_results[$];
  int unsigned       mismatches;

  function automatic int unsigned level_step(logic [RadixW-1:0] radix, logic [ChanW-1:0] scale);
    if (radix < 2) return 0;
    return scale / (radix - 1);
  endfunction

  // nearest multiple of step, ties upward, digit clamped at radix-1
  function automatic int unsigned nearest_digit(int unsigned v, int unsigned step,
                                                int unsigned radix);
    int unsigned lo;
    int unsigned rem;
    int unsigned d;
    lo  = v / step;
    rem = v - lo * step;
    d   = lo;
    if (rem != 0 && step - rem <= rem) d = lo + 1;
    if (d > radix - 1) d = radix - 1;
    return d;
  endfunction

  function automatic codec_result_t predict_codes(pidc_op_e op, logic [IdW-1:0] id,
                                                 logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                                 logic [ChanW-1:0] b);
    codec_result_t res;
    int unsigned   step;
    int unsigned   rad;
    int unsigned   r2;
    int unsigned   r3;
    int unsigned   dr;
    int unsigned   dg;
    int unsigned   db;
    res  = '0;
    rad  = radix_q;
    step = level_step(radix_q, scale_q);
    if (step == 0) return res;
    r2 = rad * rad;
    r3 = r2 * rad;
    if (op == OP_ID_TO_COLOR) begin
      if (id >= r3) return res;
      dr = id / r2;
      dg = (id - dr * r2) / rad;
      db = id - dr * r2 - dg * rad;
      res.ok    = 1'b1;
      res.red   = ChanW'(dr * step);
      res.green = ChanW'(dg * step);
      res.blue  = ChanW'(db * step);
    end else begin
      dr = nearest_digit(r, step, rad);
      dg = nearest_digit(g, step, rad);
      db = nearest_digit(b, step, rad);
      res.ok = 1'b1;
      res.id = IdW'(dr * r2 + dg * rad + db);
    end
    return res;
  endfunction

  task automatic flag_failure(string what, codec_result_t want, codec_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected ok=%0d rgb=%0d/%0d/%0d id=%0d, got ok=%0d rgb=%0d/%0d/%0d id=%0d",
               $realtime, what, want.ok, want.red, want.green, want.blue, want.id,
               got.ok, got.red, got.green, got.blue, got.id);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    codec_result_t got;
    codec_result_t want;
    if (!rst_ni) begin
      radix_q      <= RadixW'(256);
      scale_q      <= ChanW'(255);
      awaited_results.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{ok: ok_i, red: red_level_i, green: green_level_i, blue: blue_level_i,
                id: decoded_id_i};
        if (awaited_results.size() == 0) begin
          flag_failure("result with no transaction awaited", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) flag_failure("result mismatch", want, got);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(predict_codes(pidc_op_e'(op_i), object_id_i, red_in_i,
                                                green_in_i, blue_in_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (pidc_cfg_idx_e'(cfg_index_i))
          CFG_DIGIT_RADIX: radix_q <= cfg_data_i;
          CFG_FULL_SCALE:  scale_q <= cfg_data_i[ChanW-1:0];
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the picking-ID color codec. Checking lives in the
// checker instance; this module only drives the ports and ends the run.
module tb_top;
  import pidc_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned RandomItems = 1375;
  localparam int unsigned QuietItems  = 150;     // tail of the run with no idling
  localparam int unsigned HoldAfter   = 300;     // transactions before the long output hold
  localparam int unsigned LongHold    = 80;      // cycles; far more than the pipeline depth
  localparam int unsigned DrainCycles = 4 * NumStages;
  localparam int unsigned CycleLimit  = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                op_i;
  logic [IdW-1:0]      object_id_i;
  logic [ChanW-1:0]    red_in_i;
  logic [ChanW-1:0]    green_in_i;
  logic [ChanW-1:0]    blue_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                ok_o;
  logic [ChanW-1:0]    red_level_o;
  logic [ChanW-1:0]    green_level_o;
  logic [ChanW-1:0]    blue_level_o;
  logic [IdW-1:0]      decoded_id_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned sent_count;
  int unsigned cycle_count;
  bit          quiet;
  bit          long_hold_done;
  int unsigned cur_radix;    // shadow of the registers, only used to shape stimulus
  int unsigned cur_scale;

  picking_id_color_codec_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .object_id_i   (object_id_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o),
    .decoded_id_o  (decoded_id_o)
  );

  pidc_codec_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .op_i          (op_i),
    .object_id_i   (object_id_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_i          (ok_o),
    .red_level_i   (red_level_o),
    .green_level_i (green_level_o),
    .blue_level_i  (blue_level_o),
    .decoded_id_i  (decoded_id_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Run guard: a hung handshake ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned shadow_step();
    if (cur_radix < 2) return 0;
    return cur_scale / (cur_radix - 1);
  endfunction

  // Channel value biased toward step multiples, halfway points and overflow.
  function automatic logic [ChanW-1:0] pick_channel();
    int unsigned step;
    int unsigned v;
    step = shadow_step();
    if (step == 0 || $urandom_range(0, 2) == 0) return ChanW'($urandom_range(0, 255));
    v = $urandom_range(0, cur_radix - 1) * step;
    case ($urandom_range(0, 3))
      0:       v = v;
      1:       v = v + step / 2;
      2:       v = v + (step + 1) / 2;
      default: v = v + step - 1 + $urandom_range(0, 2);
    endcase
    if (v > 255) v = 255;
    return ChanW'(v);
  endfunction

  // Offer one transaction; called at a falling edge, returns at a falling edge.
  // Valid stays high into the next call unless an idle burst is taken.
  task automatic send_item(pidc_op_e op, logic [IdW-1:0] id, logic [ChanW-1:0] r,
                           logic [ChanW-1:0] g, logic [ChanW-1:0] b);
    in_valid_i  <= 1'b1;
    op_i        <= op;
    object_id_i <= id;
    red_in_i    <= r;
    green_in_i  <= g;
    blue_in_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(pidc_cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DIGIT_RADIX) cur_radix = data;
    else                        cur_scale = data[ChanW-1:0];
    @(negedge clk_i);
  endtask

  // Registers change only with the pipeline empty; both are written in random order.
  task automatic set_config(logic [CfgDataW-1:0] radix_data, logic [CfgDataW-1:0] scale_data);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_DIGIT_RADIX, radix_data);
      write_reg(CFG_FULL_SCALE, scale_data);
    end else begin
      write_reg(CFG_FULL_SCALE, scale_data);
      write_reg(CFG_DIGIT_RADIX, radix_data);
    end
  endtask

  // Output side: random stall bursts, plus one long hold so the pipeline fills
  // and in_stall_o must rise while transactions keep being offered.
  initial begin
    out_stall_i    = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && sent_count >= HoldAfter) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        out_stall_i    <= 1'b0;
        long_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned         done_items;
    int unsigned         len;
    int unsigned         step;
    int unsigned         r3;
    int unsigned         sel;
    logic [CfgDataW-1:0] radix_d;
    logic [CfgDataW-1:0] scale_d;
    logic [IdW-1:0]      id;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DIGIT_RADIX;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = OP_ID_TO_COLOR;
    object_id_i = '0;
    red_in_i    = '0;
    green_in_i  = '0;
    blue_in_i   = '0;
    sent_count  = 0;
    quiet       = 1'b0;
    cur_radix   = 256;
    cur_scale   = 255;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // full 8-bit channels, step 1: largest id, all-zero and all-ones colors
    set_config(9'd256, 9'd255);
    send_item(OP_ID_TO_COLOR, 24'd0, 8'hA5, 8'h5A, 8'hFF);
    send_item(OP_ID_TO_COLOR, 24'hFFFFFF, 8'h00, 8'hFF, 8'h0F);
    send_item(OP_COLOR_TO_ID, 24'h5A5A5A, 8'd0, 8'd128, 8'd255);
    send_item(OP_COLOR_TO_ID, 24'hFFFFFF, 8'd255, 8'd255, 8'd255);
    // smallest radix, step 255: id just in and just out of range, rounding near midpoint
    set_config(9'd2, 9'd255);
    send_item(OP_ID_TO_COLOR, 24'd7, 8'd0, 8'd0, 8'd0);
    send_item(OP_ID_TO_COLOR, 24'd8, 8'd1, 8'd2, 8'd3);
    send_item(OP_COLOR_TO_ID, 24'd0, 8'd127, 8'd128, 8'd255);
    // step 2 with full scale 9: odd inputs sit on ties, 9 overflows the top digit
    set_config(9'd5, 9'd9);
    send_item(OP_ID_TO_COLOR, 24'd124, 8'd0, 8'd0, 8'd0);
    send_item(OP_ID_TO_COLOR, 24'd125, 8'd0, 8'd0, 8'd0);
    send_item(OP_COLOR_TO_ID, 24'd0, 8'd3, 8'd9, 8'd255);
    send_item(OP_COLOR_TO_ID, 24'd0, 8'd1, 8'd8, 8'd4);
    // smallest full scale
    set_config(9'd2, 9'd1);
    send_item(OP_ID_TO_COLOR, 24'd7, 8'd0, 8'd0, 8'd0);
    send_item(OP_COLOR_TO_ID, 24'd0, 8'd0, 8'd1, 8'd255);
    // zero step: radix 1, radix 0, radix beyond 256, scale below radix-1
    set_config(9'd1, 9'd255);
    send_item(OP_ID_TO_COLOR, 24'd0, 8'd0, 8'd0, 8'd0);
    send_item(OP_COLOR_TO_ID, 24'd0, 8'd10, 8'd20, 8'd30);
    set_config(9'd0, 9'd255);
    send_item(OP_ID_TO_COLOR, 24'd0, 8'd0, 8'd0, 8'd0);
    set_config(9'h1FF, 9'h1FF);
    send_item(OP_COLOR_TO_ID, 24'd0, 8'd255, 8'd255, 8'd255);
    send_item(OP_ID_TO_COLOR, 24'd1, 8'd0, 8'd0, 8'd0);
    set_config(9'd10, 9'd5);
    send_item(OP_ID_TO_COLOR, 24'd3, 8'd0, 8'd0, 8'd0);
    send_item(OP_COLOR_TO_ID, 24'd0, 8'd5, 8'd5, 8'd5);
    set_config(9'd256, 9'd254);
    send_item(OP_COLOR_TO_ID, 24'd0, 8'd1, 8'd2, 8'd3);
    // step 2, radix 9: tie at 1, top digit at 15, clamp at 17
    set_config(9'd9, 9'd16);
    send_item(OP_COLOR_TO_ID, 24'd0, 8'd1, 8'd15, 8'd17);
    send_item(OP_ID_TO_COLOR, 24'd728, 8'd0, 8'd0, 8'd0);

    // ---- random part: phases with a fresh setting each ----
    done_items = 0;
    while (done_items < RandomItems) begin
      quiet = (done_items >= RandomItems - QuietItems);
      sel   = quiet ? 5 : $urandom_range(0, 9);
      if (sel == 0) begin
        radix_d = 9'd256;
        scale_d = 9'd255;
      end else if (sel <= 7) begin
        // well-formed setting; small radices favored so all digits get hit
        radix_d = (sel == 1) ? 9'd2 : CfgDataW'($urandom_range(2, (sel < 5) ? 16 : 256));
        scale_d = CfgDataW'($urandom_range(radix_d - 1, 255));
        scale_d[CfgDataW-1] = 1'($urandom_range(0, 1));   // unused bit of the scale register
      end else begin
        radix_d = CfgDataW'($urandom_range(0, 511));
        scale_d = CfgDataW'($urandom_range(0, 511));
      end
      set_config(radix_d, scale_d);

      if (quiet) len = RandomItems - done_items;
      else       len = $urandom_range(40, 120);
      if (!quiet && done_items + len > RandomItems - QuietItems) begin
        len = RandomItems - QuietItems - done_items;
      end

      step = shadow_step();
      r3   = cur_radix * cur_radix * cur_radix;
      repeat (len) begin
        if ($urandom_range(0, 1) == 0) begin
          if (step == 0 || $urandom_range(0, 3) == 0) begin
            id = IdW'($urandom);
          end else begin
            case ($urandom_range(0, 5))
              0:       id = IdW'(r3 - 1);
              1:       id = (r3 < (1 << IdW)) ? IdW'(r3) : IdW'($urandom);
              default: id = IdW'($urandom_range(0, r3 - 1));
            endcase
          end
          send_item(OP_ID_TO_COLOR, id, ChanW'($urandom), ChanW'($urandom), ChanW'($urandom));
        end else begin
          send_item(OP_COLOR_TO_ID, IdW'($urandom), pick_channel(), pick_channel(),
                    pick_channel());
        end
      end
      done_items += len;
    end

    // ---- drain and verdict ----
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pidc_pkg.sv
rtl/pidc_cfg.sv
rtl/pidc_enc.sv
rtl/pidc_dec.sv
rtl/picking_id_color_codec_unit.sv
tb/sv/pidc_codec_checker.sv
tb/sv/tb_top.sv
